### rtl/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and codes for the slot owner allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package soa_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_DEFRAG = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NO_WINDOW = 2'd2,
    STAT_BAD_OWNER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_COUNT,
    ST_SEEK,
    ST_MOVE,
    ST_DONE
  } state_t;

  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned OWNER_W  = 8;
  localparam int unsigned WSTART_W = 8;

endpackage

`default_nettype wire

### rtl/soa_cell.sv
// ----------------------------------------------------------------------------
// soa_cell
// One slot of the owner ring: holds an owner id and takes its neighbor's
// value whenever the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_cell #(
  parameter int unsigned OWNER_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  shift,
  input  wire logic [OWNER_BITS-1:0] d,
  output logic      [OWNER_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

### rtl/soa_ctrl.sv
// ----------------------------------------------------------------------------
// soa_ctrl
// Sequencer at the head of the owner ring: decodes a word, runs any full
// rotations it needs, edits each slot as it passes, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_ctrl #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned OWNER_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    mode,
  input  wire logic [soa_pkg::SIZE_W-1:0]    alloc_size,
  input  wire logic [soa_pkg::OWNER_W-1:0]   owner_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [soa_pkg::SIZE_W-1:0]         free_count,
  output logic [soa_pkg::SIZE_W-1:0]         affected_count,
  output logic [soa_pkg::WSTART_W-1:0]       window_start,
  input  wire logic [OWNER_BITS-1:0]         head,
  output logic [OWNER_BITS-1:0]              tail,
  output logic                               ring_shift
);

  import soa_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned NW = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int unsigned XW = CW + 1;
  localparam logic [IW-1:0] LAST_POS = IW'(SLOTS - 1);

  state_t              state, state_next;
  logic [IW-1:0]       pos;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       run, run_next;
  logic [IW-1:0]       start, start_next;
  logic                found, found_next;
  logic [CW-1:0]       free, free_next;
  logic [OWNER_BITS-1:0] own;
  logic [SIZE_W-1:0]   want;
  status_t             res_status, res_status_next;

  logic [15:0]           owner_ext;
  logic [OWNER_BITS-1:0] own_in;
  logic                  accept;
  logic                  last;
  logic                  hit_own;
  logic                  hit_free;
  logic                  in_window;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         diff_x;
  logic                  load_out;

  assign owner_ext = {8'd0, owner_id};
  assign own_in    = owner_ext[OWNER_BITS-1:0];
  assign accept    = in_valid && in_ready;
  assign last      = (pos == LAST_POS);
  assign hit_own   = (head == own);
  assign hit_free  = (head == '0);
  assign pos_x     = XW'(pos);
  assign diff_x    = pos_x - XW'(start);
  assign in_window = (pos >= start) && (diff_x < XW'(cnt));
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode != MODE_NOP && own_in == '0) begin
            state_next = ST_DONE;
          end else begin
            case (mode)
              MODE_ALLOC: begin
                if (NW'(alloc_size) > NW'(free)) state_next = ST_DONE;
                else                              state_next = ST_ALLOC;
              end
              MODE_FREE:   state_next = ST_FREE;
              MODE_DEFRAG: state_next = ST_COUNT;
              default:     state_next = ST_DONE;
            endcase
          end
        end
      end
      ST_ALLOC, ST_FREE, ST_MOVE: begin
        if (last) state_next = ST_DONE;
      end
      ST_COUNT: begin
        if (last) state_next = (cnt_next == '0) ? ST_DONE : ST_SEEK;
      end
      ST_SEEK: begin
        if (last) state_next = found_next ? ST_MOVE : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and ring control
  always_comb begin
    in_ready   = (state == ST_IDLE);
    ring_shift = (state == ST_ALLOC) || (state == ST_FREE) || (state == ST_COUNT) ||
                 (state == ST_SEEK) || (state == ST_MOVE);
  end

  // per-slot edit at the ring head
  always_comb begin
    tail            = head;
    cnt_next        = cnt;
    run_next        = run;
    start_next      = start;
    found_next      = found;
    free_next       = free;
    res_status_next = res_status;
    case (state)
      ST_IDLE: begin
        cnt_next   = '0;
        run_next   = '0;
        start_next = '0;
        found_next = 1'b0;
        if (mode != MODE_NOP && own_in == '0) begin
          res_status_next = STAT_BAD_OWNER;
        end else if (mode == MODE_ALLOC && NW'(alloc_size) > NW'(free)) begin
          res_status_next = STAT_NO_SPACE;
        end else begin
          res_status_next = STAT_OK;
        end
      end
      ST_ALLOC: begin
        if (hit_free && NW'(cnt) < NW'(want)) begin
          tail     = own;
          cnt_next = cnt + 1'b1;
        end
        if (last) free_next = free - cnt_next;
      end
      ST_FREE: begin
        if (hit_own) begin
          tail     = '0;
          cnt_next = cnt + 1'b1;
        end
        if (last) free_next = free + cnt_next;
      end
      ST_COUNT: begin
        if (hit_own) cnt_next = cnt + 1'b1;
      end
      ST_SEEK: begin
        if (hit_free || hit_own) begin
          run_next = run + 1'b1;
          if (!found && run_next == cnt) begin
            found_next = 1'b1;
            start_next = IW'(pos_x + XW'(1) - XW'(cnt));
          end
        end else begin
          run_next = '0;
        end
        if (last && !found_next) begin
          res_status_next = STAT_NO_WINDOW;
          cnt_next        = '0;
        end
      end
      ST_MOVE: begin
        if (in_window)    tail = own;
        else if (hit_own) tail = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      cnt        <= '0;
      run        <= '0;
      start      <= '0;
      found      <= 1'b0;
      free       <= CW'(SLOTS);
      own        <= '0;
      want       <= '0;
      res_status <= STAT_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      run        <= run_next;
      start      <= start_next;
      found      <= found_next;
      free       <= free_next;
      res_status <= res_status_next;
      if (accept) begin
        own  <= own_in;
        want <= alloc_size;
        pos  <= '0;
      end else if (ring_shift) begin
        pos <= last ? '0 : pos + 1'b1;
      end
      if (load_out)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= res_status;
      free_count     <= SIZE_W'(free);
      affected_count <= SIZE_W'(cnt);
      window_start   <= WSTART_W'(start);
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free <= CW'(SLOTS))
    else $error("free count above table size");

  a_pos_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pos == '0))
    else $error("pass did not start at slot zero");

  a_move_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE && last) |=> (state == ST_DONE && res_status == STAT_OK))
    else $error("compaction pass did not end ok");

  a_seek_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK) |-> (cnt != '0))
    else $error("window search with empty holding");

endmodule

`default_nettype wire

### rtl/slot_owner_allocator.sv
// Owner-zero, too-large and unused-mode words go straight to their result;
// allocate and deallocate make a full rotation; defragment counts the holding,
// stops if it is empty, else seeks a window, then moves it if one is found.
// One word at a time, paced by full rotations of the slot ring;
// a stalled result holds off the next word.
// Reset: every slot is free and the free count equals SLOTS at once.
// ----------------------------------------------------------------------------
// slot_owner_allocator
// Slot owner table kept as a rotating ring of cells; a head sequencer edits
// each slot as it passes and reports one result word per input word.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_owner_allocator #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned OWNER_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    mode,
  input  wire logic [soa_pkg::SIZE_W-1:0]    alloc_size,
  input  wire logic [soa_pkg::OWNER_W-1:0]   owner_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [soa_pkg::SIZE_W-1:0]         free_count,
  output logic [soa_pkg::SIZE_W-1:0]         affected_count,
  output logic [soa_pkg::WSTART_W-1:0]       window_start
);

  import soa_pkg::*;

  logic [OWNER_BITS-1:0] slot_q [SLOTS];
  logic [OWNER_BITS-1:0] tail;
  logic                  ring_shift;

  // slot i takes slot i+1; the last cell takes the edited head value
  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    logic [OWNER_BITS-1:0] d;
    if (i == SLOTS - 1) begin : g_end
      assign d = tail;
    end else begin : g_mid
      assign d = slot_q[i+1];
    end
    soa_cell #(
      .OWNER_BITS (OWNER_BITS)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring_shift),
      .d     (d),
      .q     (slot_q[i])
    );
  end

  soa_ctrl #(
    .SLOTS      (SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .alloc_size     (alloc_size),
    .owner_id       (owner_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .free_count     (free_count),
    .affected_count (affected_count),
    .window_start   (window_start),
    .head           (slot_q[0]),
    .tail           (tail),
    .ring_shift     (ring_shift)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for slot_owner_allocator. Words go in through a
// bursty valid/ready sender. An in-bench model of the slot table predicts
// each result word. A checker compares every accepted result, field by
// field, against the oldest prediction while the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import soa_pkg::*;

  localparam int SLOTS      = 256;
  localparam int OWNER_BITS = 8;

  typedef struct packed {
    status_t             code;
    logic [SIZE_W-1:0]   free_left;
    logic [SIZE_W-1:0]   affected;
    logic [WSTART_W-1:0] wstart;
  } slot_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          mode = 2'd0;
  logic [SIZE_W-1:0]   alloc_size = '0;
  logic [OWNER_W-1:0]  owner_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [SIZE_W-1:0]   free_count;
  logic [SIZE_W-1:0]   affected_count;
  logic [WSTART_W-1:0] window_start;

  // model of the slot table
  logic [OWNER_W-1:0]  slot_owner [SLOTS];
  logic [SIZE_W-1:0]   free_slots;

  slot_result_t        pending_results [$];
  int unsigned         error_count = 0;
  int unsigned         burst_left = 0;
  int unsigned         rx_left = 0;
  int unsigned         rx_style = 0;

  slot_owner_allocator #(
    .SLOTS      (SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .alloc_size     (alloc_size),
    .owner_id       (owner_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .free_count     (free_count),
    .affected_count (affected_count),
    .window_start   (window_start)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one word to the table model and returns the result it should give.
  // With OWNER_BITS equal to the port width the owner needs no masking.
  function automatic slot_result_t apply_slot_op(input mode_t op,
                                                 input logic [SIZE_W-1:0] want,
                                                 input logic [OWNER_W-1:0] own);
    slot_result_t r;
    int           held;
    int           run;
    int           first;
    bit           found;
    r.code     = STAT_OK;
    r.affected = '0;
    r.wstart   = '0;
    held       = 0;
    run        = 0;
    first      = 0;
    found      = 1'b0;
    if (op != MODE_NOP && own == '0) begin
      r.code = STAT_BAD_OWNER;
    end else begin
      case (op)
        MODE_ALLOC: begin
          if (want > free_slots) begin
            r.code = STAT_NO_SPACE;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_owner[i] == '0 && r.affected < want) begin
                slot_owner[i] = own;
                r.affected    = r.affected + 1'b1;
              end
            end
            free_slots = free_slots - r.affected;
          end
        end
        MODE_FREE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_owner[i] == own) begin
              slot_owner[i] = '0;
              r.affected    = r.affected + 1'b1;
            end
          end
          free_slots = free_slots + r.affected;
        end
        MODE_DEFRAG: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_owner[i] == own) held++;
          end
          if (held != 0) begin
            // first run of free-or-own slots as long as the holding
            for (int i = 0; i < SLOTS && !found; i++) begin
              if (slot_owner[i] == '0 || slot_owner[i] == own) begin
                run++;
                if (run == held) begin
                  first = i + 1 - held;
                  found = 1'b1;
                end
              end else begin
                run = 0;
              end
            end
            if (!found) begin
              r.code = STAT_NO_WINDOW;
            end else begin
              for (int i = 0; i < SLOTS; i++) begin
                if (slot_owner[i] == own) slot_owner[i] = '0;
              end
              for (int i = first; i < first + held; i++) slot_owner[i] = own;
              r.affected = SIZE_W'(held);
              r.wstart   = WSTART_W'(first);
            end
          end
        end
        default: ;
      endcase
    end
    r.free_left = free_slots;
    return r;
  endfunction

  // Owner ids used by the random mix; the last four toggle the upper bits.
  function automatic logic [OWNER_W-1:0] pool_owner(input int unsigned idx);
    case (idx)
      12:      return 8'h55;
      13:      return 8'hAA;
      14:      return 8'h80;
      15:      return 8'hFF;
      default: return OWNER_W'(idx + 1);
    endcase
  endfunction

  task automatic send_word(input mode_t op, input logic [SIZE_W-1:0] want,
                           input logic [OWNER_W-1:0] own);
    int unsigned gap;
    @(negedge clk);
    in_valid   = 1'b1;
    mode       = op;
    alloc_size = want;
    owner_id   = own;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results = {pending_results, apply_slot_op(op, want, own)};
    // valid stays up through a burst, drops for a gap when it ends
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic test_invalid_owner();
    send_word(MODE_ALLOC, 9'd5, 8'd0);
    send_word(MODE_FREE, 9'd0, 8'd0);
    send_word(MODE_DEFRAG, 9'd0, 8'd0);
  endtask

  task automatic test_unused_mode();
    send_word(MODE_NOP, 9'd511, 8'd0);
    send_word(MODE_NOP, 9'd0, 8'd255);
  endtask

  task automatic test_alloc_limits();
    send_word(MODE_ALLOC, 9'd0, 8'd255);
    send_word(MODE_ALLOC, 9'd256, 8'd255);
    send_word(MODE_ALLOC, 9'd511, 8'd3);
    send_word(MODE_DEFRAG, 9'd0, 8'd255);   // whole table is one window
    send_word(MODE_FREE, 9'd0, 8'd255);
  endtask

  task automatic test_defrag_windows();
    send_word(MODE_ALLOC, 9'd4, 8'd1);
    send_word(MODE_ALLOC, 9'd4, 8'd2);
    send_word(MODE_ALLOC, 9'd4, 8'd1);      // owner 1 grows, now split
    send_word(MODE_ALLOC, 9'd244, 8'd3);
    send_word(MODE_DEFRAG, 9'd0, 8'd1);     // no run of 8 exists
    send_word(MODE_FREE, 9'd0, 8'd3);
    send_word(MODE_DEFRAG, 9'd0, 8'd1);     // lands after owner 2
    send_word(MODE_DEFRAG, 9'd0, 8'd200);   // empty holding
    send_word(MODE_FREE, 9'd0, 8'd99);
    send_word(MODE_FREE, 9'd0, 8'd1);
    send_word(MODE_FREE, 9'd0, 8'd2);
    send_word(MODE_ALLOC, 9'd255, 8'd10);
    send_word(MODE_ALLOC, 9'd1, 8'd11);
    send_word(MODE_DEFRAG, 9'd0, 8'd11);    // window at the last slot
    send_word(MODE_FREE, 9'd0, 8'd10);
    send_word(MODE_FREE, 9'd0, 8'd11);
  endtask

  task automatic test_random_mix(input int unsigned n_words);
    mode_t              op;
    logic [SIZE_W-1:0]  want;
    logic [OWNER_W-1:0] own;
    int unsigned        roll;
    for (int k = 0; k < n_words; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = MODE_ALLOC;
      else if (roll < 70) op = MODE_FREE;
      else if (roll < 95) op = MODE_DEFRAG;
      else                op = MODE_NOP;
      // arbitrary owners only where they can't leave slots behind
      roll = $urandom_range(0, 99);
      if (roll < 4)                            own = '0;
      else if (op != MODE_ALLOC && roll < 14)  own = OWNER_W'($urandom_range(1, 255));
      else                                     own = pool_owner($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 80)      want = SIZE_W'($urandom_range(0, 40));
      else if (roll < 95) want = SIZE_W'($urandom_range(0, 256));
      else                want = SIZE_W'($urandom);
      send_word(op, want, own);
    end
  endtask

  // Many owners with tiny holdings break the table up so defragment often
  // finds no window.
  task automatic test_fragmented_defrag(input int unsigned n_words);
    mode_t       op;
    int unsigned roll;
    for (int k = 0; k < 16; k++) send_word(MODE_FREE, '0, pool_owner(k));
    for (int k = 0; k < n_words; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50)      op = MODE_ALLOC;
      else if (roll < 78) op = MODE_FREE;
      else                op = MODE_DEFRAG;
      send_word(op, SIZE_W'($urandom_range(1, 4)), OWNER_W'($urandom_range(1, 40)));
    end
  endtask

  // receiver: a new style is drawn each time the run counter runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left  = $urandom_range(50, 600);
    end else begin
      rx_left--;
    end
    case (rx_style)
      0:       out_ready = 1'b1;
      1:       out_ready = $urandom_range(0, 1);
      2:       out_ready = (rx_left % 8) == 0;
      default: out_ready = (rx_left % 64) >= 40;
    endcase
  end

  always @(posedge clk) begin : check_results
    slot_result_t want_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with none pending: status %0d", status);
        error_count++;
      end else begin
        want_r = pending_results.pop_front();
        if (status !== want_r.code) begin
          $error("status: expected %0d, got %0d", want_r.code, status);
          error_count++;
        end
        if (free_count !== want_r.free_left) begin
          $error("free_count: expected %0d, got %0d", want_r.free_left, free_count);
          error_count++;
        end
        if (affected_count !== want_r.affected) begin
          $error("affected_count: expected %0d, got %0d", want_r.affected, affected_count);
          error_count++;
        end
        if (window_start !== want_r.wstart) begin
          $error("window_start: expected %0d, got %0d", want_r.wstart, window_start);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_owner[i] = '0;
    free_slots = SIZE_W'(SLOTS);
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_invalid_owner();
    test_unused_mode();
    test_alloc_limits();
    test_defrag_windows();
    test_random_mix(880);
    test_fragmented_defrag(250);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * SLOTS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/soa_pkg.sv
rtl/soa_cell.sv
rtl/soa_ctrl.sv
rtl/slot_owner_allocator.sv
verif/testbench.sv
